### hdl/hgng_pkg.sv
// Package for the high-pass / gain / noise-gate block.
// Holds register indexes, reset values, field widths and shared types.
// No dependencies.
package hgng_pkg;

    localparam int SampleW  = 16;
    localparam int OperandW = 17;
    localparam int ProductW = 2 * OperandW;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 16;

    // Configuration register indexes
    localparam logic [CfgAddrW-1:0] RegFilterPole     = 3'd0;
    localparam logic [CfgAddrW-1:0] RegFilterGain     = 3'd1;
    localparam logic [CfgAddrW-1:0] RegLocalGain      = 3'd2;
    localparam logic [CfgAddrW-1:0] RegNoiseThreshold = 3'd3;
    localparam logic [CfgAddrW-1:0] RegHangLength     = 3'd4;

    // Register reset values
    localparam logic signed [15:0] PoleReset      = 16'sd13335;
    localparam logic [14:0]        GainReset      = 15'd23051;
    localparam logic [15:0]        LocalGainReset = 16'd2900;
    localparam logic [14:0]        ThresholdReset = 15'd10362;
    localparam logic [7:0]         HangReset      = 8'd5;

    // Control from the sequencer to the gate tracker
    typedef struct packed {
        logic en;    // a filtered word is ready this cycle
        logic last;  // that word closes a frame
    } t_gate_ctl;

endpackage

### hdl/hgng_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hgng_pkg for operand and product widths.
module hgng_mul
    import hgng_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [OperandW-1:0] i_a,
    input  logic signed [OperandW-1:0] i_b,
    output logic signed [ProductW-1:0] o_p
);

    logic signed [ProductW-1:0] r_p;

    // One product per enabled cycle, held otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

### hdl/hgng_gate.sv
// Frame peak tracker and hang counter that form the voice gate decision.
// Depends on hgng_pkg for t_gate_ctl and sample width.
module hgng_gate
    import hgng_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_gate_ctl                 i_ctl,
    input  logic signed [SampleW-1:0] i_y,
    input  logic [14:0]               i_threshold,
    input  logic [7:0]                i_hang_length,
    output logic                      o_active
);

    logic signed [SampleW-1:0] r_max, r_min, n_max, n_min;
    logic [7:0]                r_hang;
    logic                      r_active;
    logic signed [SampleW:0]   thr_pos, thr_neg;
    logic                      loud;

    // Extremes including the current word
    always_comb begin
        n_max   = (i_y >= r_max) ? i_y : r_max;
        n_min   = (i_y < r_min) ? i_y : r_min;
        thr_pos = $signed({2'b00, i_threshold});
        thr_neg = -thr_pos;
        loud    = ($signed({n_max[SampleW-1], n_max}) > thr_pos)
               || ($signed({n_min[SampleW-1], n_min}) < thr_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= '0;
            r_min    <= '0;
            r_hang   <= '0;
            r_active <= 1'b0;
        end else if (i_ctl.en) begin
            if (i_ctl.last) begin
                // frame end: decide, then restart the extremes
                r_max <= '0;
                r_min <= '0;
                if (loud) begin
                    r_hang   <= i_hang_length;
                    r_active <= 1'b1;
                end else if (r_hang != 8'd0) begin
                    r_hang   <= r_hang - 8'd1;
                    r_active <= 1'b1;
                end else begin
                    r_active <= 1'b0;
                end
            end else begin
                r_max    <= n_max;
                r_min    <= n_min;
                r_active <= 1'b0;
            end
        end
    end

    assign o_active = r_active;

endmodule

### hdl/highpass_gain_noise_gate_top.sv
// Top level of the high-pass filter with output gain and noise gate.
// Depends on hgng_pkg, hgng_mul and hgng_gate.
//
// Each input word is one signed 16-bit sample with a frame-end mark; each
// accepted word yields exactly one output word. All three products (feedforward,
// feedback, output gain) run through a single 17x17 multiplier in turn, so a
// word passes through the FF, FB, SUM, OUT and WR states after acceptance, its
// result is loaded into the output register on leaving WR, and the block takes
// no new word before that load. o_ready is high only while the sequencer is
// idle; a finished result waiting in the output register does not hold off the
// next word, only the final load of the following result. Configuration writes
// go through i_cfg_we/i_cfg_addr/i_cfg_data and should be made only while the
// block is idle; indexes past the last register are ignored.
module highpass_gain_noise_gate_top
    import hgng_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CfgAddrW-1:0]       i_cfg_addr,
    input  logic [CfgDataW-1:0]       i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SampleW-1:0] i_sample_in,
    input  logic                      i_frame_end,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SampleW-1:0] o_sample_out,
    output logic                      o_frame_last,
    output logic                      o_voice_active
);

    typedef enum logic [2:0] {
        S_IDLE, S_FF, S_FB, S_SUM, S_OUT, S_WR
    } t_state;

    // Configuration registers
    logic signed [15:0] r_pole;
    logic [14:0]        r_gain;
    logic [15:0]        r_local_gain;
    logic [14:0]        r_threshold;
    logic [7:0]         r_hang_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole        <= PoleReset;
            r_gain        <= GainReset;
            r_local_gain  <= LocalGainReset;
            r_threshold   <= ThresholdReset;
            r_hang_length <= HangReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegFilterPole:     r_pole        <= $signed(i_cfg_data);
                RegFilterGain:     r_gain        <= i_cfg_data[14:0];
                RegLocalGain:      r_local_gain  <= i_cfg_data;
                RegNoiseThreshold: r_threshold   <= i_cfg_data[14:0];
                RegHangLength:     r_hang_length <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Divide by 2^sh, rounding toward zero
    function automatic logic signed [ProductW-1:0] trunc_shift(
        input logic signed [ProductW-1:0] p,
        input logic [3:0]                 sh
    );
        logic signed [ProductW-1:0] bias;
        bias = p[ProductW-1] ? ((ProductW'(1) <<< sh) - ProductW'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

    // Sequencer and datapath registers
    t_state                    r_state, n_state;
    logic signed [SampleW-1:0] r_x, n_x;
    logic                      r_last, n_last;
    logic signed [OperandW-1:0] r_diff, n_diff;
    logic signed [SampleW-1:0] r_prev_in, n_prev_in;
    logic signed [SampleW-1:0] r_prev_y, n_prev_y;
    logic signed [18:0]        r_ff, n_ff;
    logic                      r_out_valid, n_out_valid;
    logic signed [SampleW-1:0] r_out_sample, n_out_sample;
    logic                      r_out_last, n_out_last;
    logic                      r_out_active, n_out_active;

    logic signed [OperandW-1:0] mul_a, mul_b;
    logic                       mul_en;
    logic signed [ProductW-1:0] prod;
    logic signed [ProductW-1:0] ff_q, fb_q, sc_q;
    logic signed [18:0]         y_sum;
    logic signed [SampleW-1:0]  y_clamped;
    logic signed [SampleW-1:0]  sc_sat;
    t_gate_ctl                  gate_ctl;
    logic                       gate_active;
    logic                       accept;

    assign accept = i_valid && (r_state == S_IDLE);

    // Operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_FF: begin
                mul_en = 1'b1;
                mul_a  = r_diff;
                mul_b  = $signed({2'b00, r_gain});
            end
            S_FB: begin
                mul_en = 1'b1;
                mul_a  = OperandW'(r_prev_y);
                mul_b  = OperandW'(r_pole);
            end
            S_OUT: begin
                mul_en = 1'b1;
                mul_a  = OperandW'(r_prev_y);
                mul_b  = $signed({1'b0, r_local_gain});
            end
            default: ;
        endcase
    end

    hgng_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Scaling, sum and clamps on the registered product
    always_comb begin
        ff_q  = trunc_shift(prod, 4'd14);
        fb_q  = trunc_shift(prod, 4'd15);
        sc_q  = trunc_shift(prod, 4'd12);
        y_sum = r_ff + fb_q[18:0];
        if (y_sum > 19'sd32767) begin
            y_clamped = 16'sd32767;
        end else if (y_sum < -19'sd32767) begin
            y_clamped = -16'sd32767;
        end else begin
            y_clamped = y_sum[SampleW-1:0];
        end
        if (sc_q > ProductW'(32767)) begin
            sc_sat = 16'sh7fff;
        end else if (sc_q < -ProductW'(32768)) begin
            sc_sat = 16'sh8000;
        end else begin
            sc_sat = sc_q[SampleW-1:0];
        end
    end

    assign gate_ctl.en   = (r_state == S_SUM);
    assign gate_ctl.last = r_last;

    hgng_gate u_gate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (gate_ctl),
        .i_y           (y_clamped),
        .i_threshold   (r_threshold),
        .i_hang_length (r_hang_length),
        .o_active      (gate_active)
    );

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_last       = r_last;
        n_diff       = r_diff;
        n_prev_in    = r_prev_in;
        n_prev_y     = r_prev_y;
        n_ff         = r_ff;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        n_out_active = r_out_active;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_x     = i_sample_in;
                    n_last  = i_frame_end;
                    n_diff  = OperandW'(i_sample_in) - OperandW'(r_prev_in);
                    n_state = S_FF;
                end
            end
            S_FF:  n_state = S_FB;
            S_FB: begin
                n_ff    = ff_q[18:0];
                n_state = S_SUM;
            end
            S_SUM: begin
                // y becomes the next feedback value
                n_prev_y  = y_clamped;
                n_prev_in = r_x;
                n_state   = S_OUT;
            end
            S_OUT: n_state = S_WR;
            S_WR: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = sc_sat;
                    n_out_last   = r_last;
                    n_out_active = gate_active;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev_in   <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_prev_in   <= n_prev_in;
            r_prev_y    <= n_prev_y;
        end
        r_x          <= n_x;
        r_last       <= n_last;
        r_diff       <= n_diff;
        r_ff         <= n_ff;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_active <= n_out_active;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_sample_out   = r_out_sample;
    assign o_frame_last   = r_out_last;
    assign o_voice_active = r_out_active;

endmodule

### hdl/hgng_checker.sv
// Port-level checker for highpass_gain_noise_gate_top, bound to the top level.
// Depends on hgng_pkg for widths.
module hgng_checker
    import hgng_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic signed [SampleW-1:0] o_sample_out,
    input logic                      o_frame_last,
    input logic                      o_voice_active
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out)
            && $stable(o_frame_last) && $stable(o_voice_active))
        else $error("output word changed while stalled");

    // Gate decision only appears on a frame's last word
    a_active_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_voice_active |-> o_frame_last)
        else $error("voice_active without frame_last");

    // The block is busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accept");

    // No output word straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind highpass_gain_noise_gate_top hgng_checker u_hgng_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sample_out   (o_sample_out),
    .o_frame_last   (o_frame_last),
    .o_voice_active (o_voice_active)
);
